[sv/bsc_pkg.sv]
// bsc_pkg: shared constants, command and register codes, and the control
// and status bundles passed between the sequencer and the datapath
// depends on nothing
package bsc_pkg;

    localparam int MAX_PROCS_DEF   = 16;
    localparam int MAX_RES_DEF     = 8;
    localparam int AMOUNT_BITS_DEF = 16;

    localparam int PCOUNT_W = 5;
    localparam int RCOUNT_W = 4;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_MAX   = 2'd1,
        CMD_AVAIL = 2'd2,
        CMD_RUN   = 2'd3
    } cmd_t;

    localparam logic REG_PROCESS_COUNT  = 1'b0;
    localparam logic REG_RESOURCE_COUNT = 1'b1;

    // datapath actions of one microcode step
    typedef struct packed {
        logic load_work;
        logic clr_fin;
        logic clr_p;
        logic inc_p;
        logic clr_r;
        logic inc_r;
        logic set_fin;
        logic set_prog;
        logic clr_prog;
        logic add_work;
        logic push_grant;
        logic push_verdict;
    } act_t;

    // datapath conditions seen by the sequencer
    typedef struct packed {
        logic run;
        logic p_lt;
        logic prog;
        logic fin;
        logic r_lt;
        logic no_fit;
        logic out_busy;
    } status_t;

endpackage

[sv/bankers_safety_check_top.sv]
// Banker's-algorithm safety check. Load requests (allocation, maximum, available) are taken one
// per cycle while the block is idle and produce no result. A run request then walks the tables:
// it loads work, examines each unfinished process resource by resource, grants a process whose
// need fits and adds its allocation to work, ends each pass and repeats while a pass granted, then
// emits the verdict; each grant or verdict waits while the previous result is held back by
// out_ready. The allocation and maximum memories have registered reads at a shared address.
// bankers_safety_check_top: datapath, config registers, output register
// depends on bsc_pkg, bsc_ram, bsc_sequencer
module bankers_safety_check_top #(
    parameter int MAX_PROCS   = bsc_pkg::MAX_PROCS_DEF,
    parameter int MAX_RES     = bsc_pkg::MAX_RES_DEF,
    parameter int AMOUNT_BITS = bsc_pkg::AMOUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [3:0]  proc_index,
    input  logic [2:0]  res_index,
    input  logic [15:0] amount,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  granted_proc,
    output logic        is_verdict,
    output logic        safe,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bsc_pkg::*;

    localparam int WORK_BITS = AMOUNT_BITS + 6;
    localparam int DEPTH     = MAX_PROCS * MAX_RES;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PCNT_W    = $clog2(MAX_PROCS + 1);
    localparam int PIDX_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int RCNT_W    = $clog2(MAX_RES + 1);
    localparam int RIDX_W    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;

    logic [PCOUNT_W-1:0]    process_count_reg;
    logic [RCOUNT_W-1:0]    resource_count_reg;
    logic [PCNT_W-1:0]      np;
    logic [RCNT_W-1:0]      nr;

    logic [PCNT_W-1:0]      p_reg;
    logic [RCNT_W-1:0]      r_reg;
    logic                   prog_reg;
    logic [MAX_PROCS-1:0]   fin_reg;
    logic [WORK_BITS-1:0]   work_reg [MAX_RES];
    logic [AMOUNT_BITS-1:0] avail_reg [MAX_RES];

    logic                   out_valid_reg;
    logic [3:0]             granted_reg;
    logic                   verdict_reg;
    logic                   safe_reg;
    logic                   last_reg;

    logic [PIDX_W-1:0]      p_idx;
    logic [RIDX_W-1:0]      r_idx;
    logic [RIDX_W-1:0]      ld_r_idx;
    logic                   in_accept;
    logic                   ld_ok;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic [AMOUNT_BITS-1:0] ld_amount;
    logic [AMOUNT_BITS-1:0] alloc_rd;
    logic [AMOUNT_BITS-1:0] max_rd;
    logic [AMOUNT_BITS-1:0] need;
    logic [WORK_BITS:0]     work_sum;
    logic [MAX_PROCS-1:0]   use_mask;
    logic                   all_done;
    logic                   out_busy;
    logic                   cfg_wr;
    logic                   seq_idle;
    status_t                status;
    act_t                   act;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_count_reg  <= PCOUNT_W'(1);
            resource_count_reg <= RCOUNT_W'(1);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_PROCESS_COUNT:  process_count_reg  <= pwdata[PCOUNT_W-1:0];
                REG_RESOURCE_COUNT: resource_count_reg <= pwdata[RCOUNT_W-1:0];
                default:            process_count_reg  <= process_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_PROCESS_COUNT:  prdata = 32'(process_count_reg);
            REG_RESOURCE_COUNT: prdata = 32'(resource_count_reg);
            default:            prdata = '0;
        endcase
    end

    assign np = (32'(process_count_reg) > 32'(MAX_PROCS)) ? PCNT_W'(MAX_PROCS)
                                                           : PCNT_W'(process_count_reg);
    assign nr = (32'(resource_count_reg) > 32'(MAX_RES)) ? RCNT_W'(MAX_RES)
                                                          : RCNT_W'(resource_count_reg);

    // load path
    assign in_ready  = seq_idle;
    assign in_accept = in_valid && in_ready;
    assign ld_ok     = in_accept && (command != CMD_RUN) &&
                       (32'(proc_index) < 32'(MAX_PROCS)) && (32'(res_index) < 32'(MAX_RES));
    assign ld_amount = AMOUNT_BITS'(amount);
    assign ld_r_idx  = RIDX_W'(res_index);
    assign wr_addr   = AW'(32'(proc_index) * 32'(MAX_RES) + 32'(res_index));

    assign p_idx   = p_reg[PIDX_W-1:0];
    assign r_idx   = r_reg[RIDX_W-1:0];
    assign rd_addr = AW'(32'(p_idx) * 32'(MAX_RES) + 32'(r_idx));

    bsc_ram #(.WIDTH(AMOUNT_BITS), .DEPTH(DEPTH)) u_alloc_ram (
        .clk     (clk),
        .wr_en   (ld_ok && (command == CMD_ALLOC)),
        .wr_addr (wr_addr),
        .wr_data (ld_amount),
        .rd_addr (rd_addr),
        .rd_data (alloc_rd)
    );

    bsc_ram #(.WIDTH(AMOUNT_BITS), .DEPTH(DEPTH)) u_max_ram (
        .clk     (clk),
        .wr_en   (ld_ok && (command == CMD_MAX)),
        .wr_addr (wr_addr),
        .wr_data (ld_amount),
        .rd_addr (rd_addr),
        .rd_data (max_rd)
    );

    always_ff @(posedge clk)
    begin
        if (ld_ok && (command == CMD_AVAIL))
        begin
            avail_reg[ld_r_idx] <= ld_amount;
        end
    end

    // need, fit test, saturating work update
    assign need     = (max_rd > alloc_rd) ? (max_rd - alloc_rd) : '0;
    assign work_sum = {1'b0, work_reg[r_idx]} + (WORK_BITS + 1)'(alloc_rd);

    always_comb
    begin
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            use_mask[i] = (32'(i) < 32'(np));
        end
    end
    assign all_done = &(fin_reg | ~use_mask);

    assign out_busy = out_valid_reg && !out_ready;

    assign status.run      = in_accept && (command == CMD_RUN);
    assign status.p_lt     = (p_reg < np);
    assign status.prog     = prog_reg;
    assign status.fin      = fin_reg[p_idx];
    assign status.r_lt     = (r_reg < nr);
    assign status.no_fit   = (WORK_BITS'(need) > work_reg[r_idx]);
    assign status.out_busy = out_busy;

    bsc_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .act    (act),
        .idle   (seq_idle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg    <= '0;
            r_reg    <= '0;
            prog_reg <= 1'b0;
            fin_reg  <= '0;
        end
        else
        begin
            if (act.clr_p)
            begin
                p_reg <= '0;
            end
            else if (act.inc_p)
            begin
                p_reg <= p_reg + 1'b1;
            end
            if (act.clr_r)
            begin
                r_reg <= '0;
            end
            else if (act.inc_r)
            begin
                r_reg <= r_reg + 1'b1;
            end
            if (act.clr_prog)
            begin
                prog_reg <= 1'b0;
            end
            else if (act.set_prog)
            begin
                prog_reg <= 1'b1;
            end
            if (act.clr_fin)
            begin
                fin_reg <= '0;
            end
            else if (act.set_fin)
            begin
                fin_reg[p_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (act.load_work)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                work_reg[i] <= WORK_BITS'(avail_reg[i]);
            end
        end
        else if (act.add_work)
        begin
            work_reg[r_idx] <= work_sum[WORK_BITS] ? '1 : work_sum[WORK_BITS-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (act.push_grant || act.push_verdict)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act.push_grant)
        begin
            granted_reg <= 4'(p_idx);
            verdict_reg <= 1'b0;
            safe_reg    <= 1'b0;
            last_reg    <= 1'b0;
        end
        else if (act.push_verdict)
        begin
            granted_reg <= '0;
            verdict_reg <= 1'b1;
            safe_reg    <= all_done;
            last_reg    <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted_proc = granted_reg;
    assign is_verdict   = verdict_reg;
    assign safe         = safe_reg;
    assign last         = last_reg;

endmodule

[sv/bsc_ram.sv]
// bsc_ram: generic single-write, single-read ram with registered read data
// depends on nothing
module bsc_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[sv/bsc_sequencer.sv]
// bsc_sequencer: step counter and microcode rom for the safety check
// depends on bsc_pkg (act_t, status_t)
module bsc_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  bsc_pkg::status_t status,
    output bsc_pkg::act_t    act,
    output logic             idle
);
    import bsc_pkg::*;

    typedef logic [3:0] step_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_RUN,
        C_P_LT,
        C_PROG,
        C_FIN,
        C_R_LT,
        C_NO_FIT
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        logic  wait_out;
        step_t t_true;
        step_t t_false;
    } uword_t;

    localparam step_t STEP_IDLE  = 4'd0;
    localparam step_t STEP_INIT  = 4'd1;
    localparam step_t STEP_PTOP  = 4'd2;
    localparam step_t STEP_PEND  = 4'd3;
    localparam step_t STEP_PROC  = 4'd4;
    localparam step_t STEP_RD    = 4'd5;
    localparam step_t STEP_CMP   = 4'd6;
    localparam step_t STEP_GRANT = 4'd7;
    localparam step_t STEP_ARD   = 4'd8;
    localparam step_t STEP_ADD   = 4'd9;
    localparam step_t STEP_SKIP  = 4'd10;
    localparam step_t STEP_VERD  = 4'd11;
    localparam step_t STEP_EMIT  = 4'd12;

    step_t  pc_reg;
    step_t  pc_next;
    uword_t word;
    logic   cond_true;
    logic   stall;

    always_comb
    begin
        word = '{act: '0, cond: C_ALWAYS, wait_out: 1'b0,
                 t_true: STEP_IDLE, t_false: STEP_IDLE};
        case (pc_reg)
            STEP_IDLE:
            begin
                word.cond    = C_RUN;
                word.t_true  = STEP_INIT;
                word.t_false = STEP_IDLE;
            end
            STEP_INIT:
            begin
                word.act.load_work = 1'b1;
                word.act.clr_fin   = 1'b1;
                word.act.clr_p     = 1'b1;
                word.act.clr_prog  = 1'b1;
                word.t_true        = STEP_PTOP;
            end
            STEP_PTOP:
            begin
                word.cond    = C_P_LT;
                word.t_true  = STEP_PROC;
                word.t_false = STEP_PEND;
            end
            STEP_PEND:
            begin
                word.act.clr_p    = 1'b1;
                word.act.clr_prog = 1'b1;
                word.cond         = C_PROG;
                word.t_true       = STEP_PTOP;
                word.t_false      = STEP_VERD;
            end
            STEP_PROC:
            begin
                word.act.clr_r = 1'b1;
                word.cond      = C_FIN;
                word.t_true    = STEP_SKIP;
                word.t_false   = STEP_RD;
            end
            STEP_RD:
            begin
                word.cond    = C_R_LT;
                word.t_true  = STEP_CMP;
                word.t_false = STEP_GRANT;
            end
            STEP_CMP:
            begin
                word.act.inc_r = 1'b1;
                word.cond      = C_NO_FIT;
                word.t_true    = STEP_SKIP;
                word.t_false   = STEP_RD;
            end
            STEP_GRANT:
            begin
                word.act.set_fin  = 1'b1;
                word.act.set_prog = 1'b1;
                word.act.clr_r    = 1'b1;
                word.t_true       = STEP_ARD;
            end
            STEP_ARD:
            begin
                word.cond    = C_R_LT;
                word.t_true  = STEP_ADD;
                word.t_false = STEP_EMIT;
            end
            STEP_ADD:
            begin
                word.act.add_work = 1'b1;
                word.act.inc_r    = 1'b1;
                word.t_true       = STEP_ARD;
            end
            STEP_SKIP:
            begin
                word.act.inc_p = 1'b1;
                word.t_true    = STEP_PTOP;
            end
            STEP_VERD:
            begin
                word.act.push_verdict = 1'b1;
                word.wait_out         = 1'b1;
                word.t_true           = STEP_IDLE;
            end
            STEP_EMIT:
            begin
                word.act.push_grant = 1'b1;
                word.act.inc_p      = 1'b1;
                word.wait_out       = 1'b1;
                word.t_true         = STEP_PTOP;
            end
            default:
            begin
                word.t_true = STEP_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (word.cond)
            C_ALWAYS: cond_true = 1'b1;
            C_RUN:    cond_true = status.run;
            C_P_LT:   cond_true = status.p_lt;
            C_PROG:   cond_true = status.prog;
            C_FIN:    cond_true = status.fin;
            C_R_LT:   cond_true = status.r_lt;
            C_NO_FIT: cond_true = status.no_fit;
            default:  cond_true = 1'b1;
        endcase
    end

    assign stall   = word.wait_out && status.out_busy;
    assign pc_next = stall ? pc_reg : (cond_true ? word.t_true : word.t_false);
    assign act     = stall ? '0 : word.act;
    assign idle    = (pc_reg == STEP_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[sv/bsc_checker.sv]
// bsc_checker: port-level checks on the safety check block, bound to the top
// depends on bsc_pkg (command codes) and bankers_safety_check_top ports
module bsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  command,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  granted_proc,
    input logic        is_verdict,
    input logic        safe,
    input logic        last
);
    import bsc_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(granted_proc)
            && $stable(is_verdict) && $stable(safe) && $stable(last))
        else $error("result changed while stalled");

    // a run request closes the input until its verdict
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == CMD_RUN) |=> !in_ready)
        else $error("request taken during a run");

    // a load request leaves the input ready in the next cycle
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command != CMD_RUN) |=> in_ready)
        else $error("load request stalled the input");

    a_verdict_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_verdict |-> last && (granted_proc == 4'd0))
        else $error("verdict result malformed");

    a_grant_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_verdict |-> !safe && !last)
        else $error("grant result malformed");

endmodule

bind bankers_safety_check_top bsc_checker u_bsc_checker (.*);

[verif/testbench.sv]
// testbench for bankers_safety_check_top: load requests fill the ledger, run requests are
// checked grant by grant and verdict against an in-bench copy of the safety walk
// depends on bsc_pkg and bankers_safety_check_top
module testbench;
    import bsc_pkg::*;

    localparam int N_PROCS = MAX_PROCS_DEF;
    localparam int N_RES = MAX_RES_DEF;
    localparam int AMT_BITS = AMOUNT_BITS_DEF;
    localparam int WORK_BITS = AMT_BITS + 6;
    localparam logic [WORK_BITS-1:0] WORK_MAX = '1;
    localparam int CYCLE_LIMIT = 800000;
    localparam int N_PHASES = 10;
    localparam int PHASE_ITEMS = 14;

    typedef struct packed {
        cmd_t        command;
        logic [3:0]  proc_index;
        logic [2:0]  res_index;
        logic [15:0] amount;
    } bank_req_t;

    typedef struct packed {
        logic [3:0] granted_proc;
        logic       is_verdict;
        logic       safe;
        logic       last;
    } grant_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = '0;
    logic [3:0]  proc_index = '0;
    logic [2:0]  res_index = '0;
    logic [15:0] amount = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  granted_proc;
    logic        is_verdict;
    logic        safe;
    logic        last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // ledger as the block should hold it
    logic [15:0] alloc_mem [N_PROCS][N_RES];
    logic [15:0] max_mem [N_PROCS][N_RES];
    logic [15:0] avail_mem [N_RES];
    logic [4:0]  proc_cfg = 5'd1;
    logic [3:0]  res_cfg = 4'd1;

    // entries already loaded, seen from the request generator
    bit alloc_set [N_PROCS][N_RES];
    bit max_set [N_PROCS][N_RES];
    bit avail_set [N_RES];

    bank_req_t req_backlog [$];
    bank_req_t on_bus;
    grant_t    expected_grants [$];
    grant_t    due;
    int        fail_count = 0;
    int        cycle_count = 0;
    int        phase_items;
    bit        steady = 1'b0;
    int        phase_procs [N_PHASES] = '{0, 16, 3, 2, 5, 1, 0, 31, 4, 20};
    int        phase_res [N_PHASES] = '{3, 0, 2, 8, 4, 1, 0, 1, 15, 2};

    bankers_safety_check_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .proc_index(proc_index),
        .res_index(res_index),
        .amount(amount),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .granted_proc(granted_proc),
        .is_verdict(is_verdict),
        .safe(safe),
        .last(last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int active_procs();
        return (proc_cfg > N_PROCS) ? N_PROCS : int'(proc_cfg);
    endfunction

    function automatic int active_res();
        return (res_cfg > N_RES) ? N_RES : int'(res_cfg);
    endfunction

    // ledger update on loads, safe-sequence walk on runs
    task automatic apply_request(bank_req_t req);
        int np;
        int nr;
        bit progress;
        bit all_done;
        bit fits;
        bit finished [N_PROCS];
        logic [WORK_BITS-1:0] work [N_RES];
        logic [15:0] need;
        logic [WORK_BITS:0] total;
        case (req.command)
            CMD_ALLOC: alloc_mem[req.proc_index][req.res_index] = req.amount;
            CMD_MAX: max_mem[req.proc_index][req.res_index] = req.amount;
            CMD_AVAIL: avail_mem[req.res_index] = req.amount;
            default:
            begin
                np = active_procs();
                nr = active_res();
                for (int r = 0; r < N_RES; r++)
                    work[r] = WORK_BITS'(avail_mem[r]);
                for (int p = 0; p < N_PROCS; p++)
                    finished[p] = 1'b0;
                do
                begin
                    progress = 1'b0;
                    for (int p = 0; p < np; p++)
                    begin
                        if (!finished[p])
                        begin
                            fits = 1'b1;
                            for (int r = 0; r < nr; r++)
                            begin
                                need = (max_mem[p][r] > alloc_mem[p][r]) ?
                                       max_mem[p][r] - alloc_mem[p][r] : 16'd0;
                                if (WORK_BITS'(need) > work[r])
                                    fits = 1'b0;
                            end
                            if (fits)
                            begin
                                finished[p] = 1'b1;
                                progress = 1'b1;
                                for (int r = 0; r < nr; r++)
                                begin
                                    total = {1'b0, work[r]} + (WORK_BITS + 1)'(alloc_mem[p][r]);
                                    work[r] = (total > {1'b0, WORK_MAX}) ?
                                              WORK_MAX : total[WORK_BITS-1:0];
                                end
                                expected_grants.push_back('{granted_proc: 4'(p),
                                    is_verdict: 1'b0, safe: 1'b0, last: 1'b0});
                            end
                        end
                    end
                end
                while (progress);
                all_done = 1'b1;
                for (int p = 0; p < np; p++)
                    if (!finished[p])
                        all_done = 1'b0;
                expected_grants.push_back('{granted_proc: 4'd0, is_verdict: 1'b1,
                    safe: all_done, last: 1'b1});
            end
        endcase
    endtask

    function automatic logic [15:0] pick_amount(cmd_t c);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 16'h0000;
        if (roll < 10)
            return 16'hFFFF;
        if (roll < 20)
            return 16'($urandom());
        case (c)
            CMD_ALLOC: return 16'($urandom_range(0, 4));
            CMD_MAX: return 16'($urandom_range(0, 9));
            default: return 16'($urandom_range(0, 12));
        endcase
    endfunction

    task automatic queue_req(cmd_t c, int p, int r, logic [15:0] a);
        req_backlog.push_back('{command: c, proc_index: 4'(p), res_index: 3'(r), amount: a});
        case (c)
            CMD_ALLOC: alloc_set[p][r] = 1'b1;
            CMD_MAX: max_set[p][r] = 1'b1;
            CMD_AVAIL: avail_set[r] = 1'b1;
            default: ;
        endcase
    endtask

    // a run never reads an entry that was not loaded first
    task automatic queue_run();
        for (int p = 0; p < active_procs(); p++)
            for (int r = 0; r < active_res(); r++)
            begin
                if (!alloc_set[p][r])
                    queue_req(CMD_ALLOC, p, r, pick_amount(CMD_ALLOC));
                if (!max_set[p][r])
                    queue_req(CMD_MAX, p, r, pick_amount(CMD_MAX));
            end
        for (int r = 0; r < N_RES; r++)
            if (!avail_set[r])
                queue_req(CMD_AVAIL, 0, r, pick_amount(CMD_AVAIL));
        queue_req(CMD_RUN, $urandom_range(0, 15), $urandom_range(0, 7), 16'($urandom()));
    endtask

    task automatic queue_sequence();
        int n_loads;
        int np;
        int nr;
        int p;
        int r;
        cmd_t c;
        n_loads = $urandom_range(0, 8);
        np = active_procs();
        nr = active_res();
        for (int i = 0; i < n_loads; i++)
        begin
            c = cmd_t'($urandom_range(0, 2));
            p = (np == 0 || $urandom_range(0, 9) == 0) ?
                $urandom_range(0, N_PROCS - 1) : $urandom_range(0, np - 1);
            r = (nr == 0 || $urandom_range(0, 9) == 0) ?
                $urandom_range(0, N_RES - 1) : $urandom_range(0, nr - 1);
            queue_req(c, p, r, pick_amount(c));
        end
        phase_items += n_loads + 1;
        queue_run();
    endtask

    task automatic wait_until_quiet();
        while (req_backlog.size() != 0 || in_valid || expected_grants.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic apb_write(logic reg_sel, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == REG_PROCESS_COUNT)
            proc_cfg = data[4:0];
        else
            res_cfg = data[3:0];
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_request(on_bus);
            if (!in_valid || in_ready)
            begin
                if (req_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 25))
                begin
                    on_bus = req_backlog.pop_front();
                    command <= on_bus.command;
                    proc_index <= on_bus.proc_index;
                    res_index <= on_bus.res_index;
                    amount <= on_bus.amount;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // grant monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $error("unexpected result: granted_proc %0d is_verdict %0b safe %0b last %0b",
                           granted_proc, is_verdict, safe, last);
                    fail_count++;
                end
                else
                begin
                    due = expected_grants.pop_front();
                    if (granted_proc !== due.granted_proc)
                    begin
                        $error("granted_proc: expected %0d, got %0d", due.granted_proc,
                               granted_proc);
                        fail_count++;
                    end
                    if (is_verdict !== due.is_verdict)
                    begin
                        $error("is_verdict: expected %0b, got %0b", due.is_verdict, is_verdict);
                        fail_count++;
                    end
                    if (safe !== due.safe)
                    begin
                        $error("safe: expected %0b, got %0b", due.safe, safe);
                        fail_count++;
                    end
                    if (last !== due.last)
                    begin
                        $error("last: expected %0b, got %0b", due.last, last);
                        fail_count++;
                    end
                end
            end
            out_ready <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // one process, one resource at reset counts
        queue_req(CMD_ALLOC, 0, 0, 16'h0000);
        queue_req(CMD_MAX, 0, 0, 16'h0000);
        queue_req(CMD_AVAIL, 0, 0, 16'h0000);
        queue_run();
        queue_req(CMD_MAX, 0, 0, 16'hFFFF);
        queue_run();
        queue_req(CMD_AVAIL, 0, 0, 16'hFFFF);
        queue_run();
        queue_req(CMD_ALLOC, 0, 0, 16'hAAAA);
        queue_req(CMD_MAX, 0, 0, 16'h5555);
        queue_req(CMD_AVAIL, 0, 0, 16'h5555);
        queue_run();
        queue_req(CMD_ALLOC, 15, 7, 16'h5555);
        queue_req(CMD_MAX, 15, 7, 16'hAAAA);
        queue_req(CMD_AVAIL, 0, 7, 16'hFFFF);
        queue_req(CMD_MAX, 0, 0, 16'hFFFE);
        queue_run();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            wait_until_quiet();
            steady = (ph == 2);
            apb_write(REG_PROCESS_COUNT, ($urandom() << 5) | 32'(phase_procs[ph]));
            apb_write(REG_RESOURCE_COUNT, ($urandom() << 4) | 32'(phase_res[ph]));
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                queue_sequence();
        end

        wait_until_quiet();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
